FILE: rtl/core/assert_macros.svh
// Assertion shorthands shared by the checker files.
// Each macro expands to one labeled concurrent assertion reporting by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr is true at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that cons is true whenever ante is true at the same edge.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that cons is true at the edge after ante is true.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bhcds_pkg.sv
// Shared types and constants of the button drive selector.
// No dependencies; imported by the selector core.
`timescale 1ns / 1ps
`default_nettype none

package bhcds_pkg;

    localparam int unsigned CFG_DATA_BITS = 16;
    localparam int unsigned CFG_IDX_BITS  = 2;
    localparam int unsigned THR_BITS      = 16;

    localparam logic [THR_BITS-1:0] HOLD_TIME_RESET  = 16'd1000;
    localparam logic [THR_BITS-1:0] CLICK_TIME_RESET = 16'd50;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_HOLD_TIME      = 2'd0,
        CFG_CLICK_TIME     = 2'd1,
        CFG_RESTORED_DRIVE = 2'd2,
        CFG_RESTORED_LOCK  = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

FILE: rtl/core/button_hold_click_drive_selector_unit.sv
// A word accepted into the input register moves on into the result register,
// where it can be taken (input register, then result register).
// Throughput: one word per cycle while the result is not held; the button and timer
// update is one short combinational step that commits state in the cycle it fires.
// Reset (i_rst_n low, synchronous): pipeline empties, edge/timer state clears, hold and
// click times return to 1000 ms and 50 ms, drive and lock restore values return to 0.
`timescale 1ns / 1ps
`default_nettype none

module button_hold_click_drive_selector_unit
    import bhcds_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,

    // configuration write port
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,

    // sample channel
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [31:0]              i_time_ms,
    input  wire logic                     i_button_level,
    input  wire logic                     i_handbrake_level,

    // result channel
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic                          o_drive_out,
    output logic                          o_lock_out,
    output logic                          o_drive_state,
    output logic                          o_lock_state,
    output logic                          o_save_request
);

    // Timestamp bits actually carried from the port into the time base.
    localparam int unsigned NOW_BITS = (TIME_BITS < 32) ? TIME_BITS : 32;

    // Wrapped difference a - b read as signed; true only when positive and above thr.
    function automatic logic exceeds(
        input logic [TIME_BITS-1:0] a,
        input logic [TIME_BITS-1:0] b,
        input logic [THR_BITS-1:0]  thr
    );
        logic [TIME_BITS-1:0] d;
        d = a - b;
        return !d[TIME_BITS-1] && (d > TIME_BITS'(thr));
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [THR_BITS-1:0] r_hold_time;
    logic [THR_BITS-1:0] r_click_time;
    logic                r_restored_drive;
    logic                r_restored_lock;

    // ---------------------------------------------------------------
    // Input register stage
    // ---------------------------------------------------------------
    logic                 r_in_valid;
    logic [TIME_BITS-1:0] r_in_now;
    logic                 r_in_button;
    logic                 r_in_handbrake;

    // ---------------------------------------------------------------
    // Selector state
    // ---------------------------------------------------------------
    logic                 r_prev_button;
    logic [TIME_BITS-1:0] r_press_stamp;
    logic [TIME_BITS-1:0] r_release_stamp;
    logic                 r_pressed_flag;
    logic                 r_hold_flag;
    logic                 r_drive_on;
    logic                 r_lock_on;

    // ---------------------------------------------------------------
    // Result register stage
    // ---------------------------------------------------------------
    logic r_out_valid;
    logic r_out_drive;
    logic r_out_lock;
    logic r_out_drive_state;
    logic r_out_lock_state;
    logic r_out_save;

    // Handshake: the result register frees when empty or when its word is taken;
    // the input register moves into it whenever it frees, so a word can enter
    // every cycle and only a held result backs up into the sample channel.
    logic out_free;
    logic step_fire;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !out_free;
    assign step_fire  = r_in_valid && out_free;

    // ---------------------------------------------------------------
    // Next-state logic for one sample
    // ---------------------------------------------------------------
    logic [TIME_BITS-1:0] n_press_stamp;
    logic [TIME_BITS-1:0] n_release_stamp;
    logic                 n_pressed_flag;
    logic                 n_hold_flag;
    logic                 n_drive_on;
    logic                 n_lock_on;
    logic                 n_save;

    always_comb begin
        n_press_stamp   = r_press_stamp;
        n_release_stamp = r_release_stamp;
        n_pressed_flag  = r_pressed_flag;
        n_hold_flag     = r_hold_flag;
        n_drive_on      = r_drive_on;
        n_lock_on       = r_lock_on;
        n_save          = 1'b0;

        // Press edge: restart both stamps and mark the press.
        if (r_prev_button && !r_in_button) begin
            n_press_stamp   = r_in_now;
            n_release_stamp = r_in_now;
            n_pressed_flag  = 1'b1;
        end

        // Release edge: stamp the release; a release that ends a hold
        // restarts the timer so it is not also counted as a click.
        if (!r_prev_button && r_in_button) begin
            n_release_stamp = r_in_now;
            n_pressed_flag  = 1'b0;
            if (r_hold_flag) begin
                n_hold_flag     = 1'b0;
                n_press_stamp   = r_in_now;
                n_release_stamp = r_in_now;
            end
        end

        // Track time while held, until a hold has been taken.
        if (!r_in_button && !n_hold_flag) begin
            n_release_stamp = r_in_now;
        end

        // Long hold: toggle drive; dropping drive also drops lock.
        if (exceeds(n_release_stamp, n_press_stamp, r_hold_time)) begin
            n_press_stamp = r_in_now;
            n_drive_on    = !r_drive_on;
            if (r_drive_on) begin
                n_lock_on = 1'b0;
            end
            n_save      = 1'b1;
            n_hold_flag = 1'b1;
        end

        // Click after release: toggle lock, only while drive is on.
        if (exceeds(n_release_stamp, n_press_stamp, r_click_time) && !n_pressed_flag) begin
            n_press_stamp = n_release_stamp;
            if (n_drive_on) begin
                n_lock_on = !n_lock_on;
                n_save    = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_time      <= HOLD_TIME_RESET;
            r_click_time     <= CLICK_TIME_RESET;
            r_restored_drive <= 1'b0;
            r_restored_lock  <= 1'b0;
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_prev_button    <= 1'b0;
            r_press_stamp    <= '0;
            r_release_stamp  <= '0;
            r_pressed_flag   <= 1'b0;
            r_hold_flag      <= 1'b0;
            r_drive_on       <= 1'b0;
            r_lock_on        <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end

            // Config is to be written only while idle, so it never meets a step; not enforced here.
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_HOLD_TIME:  r_hold_time  <= i_cfg_data;
                    CFG_CLICK_TIME: r_click_time <= i_cfg_data;
                    CFG_RESTORED_DRIVE: begin
                        r_restored_drive <= i_cfg_data[0];
                        r_drive_on       <= i_cfg_data[0];
                    end
                    CFG_RESTORED_LOCK: begin
                        r_restored_lock <= i_cfg_data[0];
                        r_lock_on       <= i_cfg_data[0];
                    end
                    default: ;
                endcase
            end else if (step_fire) begin
                r_prev_button   <= r_in_button;
                r_press_stamp   <= n_press_stamp;
                r_release_stamp <= n_release_stamp;
                r_pressed_flag  <= n_pressed_flag;
                r_hold_flag     <= n_hold_flag;
                r_drive_on      <= n_drive_on;
                r_lock_on       <= n_lock_on;
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_now       <= TIME_BITS'(i_time_ms[NOW_BITS-1:0]);
            r_in_button    <= i_button_level;
            r_in_handbrake <= i_handbrake_level;
        end
        if (step_fire) begin
            // handbrake level low means engaged: force both drive outputs low
            r_out_drive       <= r_in_handbrake && n_drive_on;
            r_out_lock        <= r_in_handbrake && n_lock_on;
            r_out_drive_state <= n_drive_on;
            r_out_lock_state  <= n_lock_on;
            r_out_save        <= n_save;
        end
    end

    // The restore values are kept for the record; drive and lock load from the
    // write itself, so they feed no logic beyond their own registers.
    logic unused_restore;
    assign unused_restore = r_restored_drive ^ r_restored_lock;

    assign o_out_valid    = r_out_valid;
    assign o_drive_out    = r_out_drive;
    assign o_lock_out     = r_out_lock;
    assign o_drive_state  = r_out_drive_state;
    assign o_lock_state   = r_out_lock_state;
    assign o_save_request = r_out_save;

endmodule

`default_nettype wire

FILE: rtl/core/bhcds_checker.sv
// Port-level checks for the button drive selector.
// Uses assert_macros.svh; bound onto button_hold_click_drive_selector_unit.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bhcds_checker
    import bhcds_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_cfg_we,
    input wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input wire logic                     i_in_valid,
    input wire logic                     o_in_stall,
    input wire logic [31:0]              i_time_ms,
    input wire logic                     i_button_level,
    input wire logic                     i_handbrake_level,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_stall,
    input wire logic                     o_drive_out,
    input wire logic                     o_lock_out,
    input wire logic                     o_drive_state,
    input wire logic                     o_lock_state,
    input wire logic                     o_save_request
);

    logic unused_ports;
    assign unused_ports = i_cfg_we ^ (^i_cfg_index) ^ (^i_cfg_data) ^ i_in_valid
                        ^ (^i_time_ms) ^ i_button_level ^ i_handbrake_level;

    // hold a stalled result word steady
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable({o_drive_out, o_lock_out, o_drive_state, o_lock_state, o_save_request}), "stalled result word changed")

    // back-pressure only comes from a held result
    `ASSERT_IMPLIES(a_stall_src, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "sample stall without held result")

    // drive outputs never exceed the stored values
    `ASSERT_IMPLIES(a_out_masked, i_clk, i_rst_n, o_out_valid, (!o_drive_out || o_drive_state) && (!o_lock_out || o_lock_state), "drive output set while stored value clear")

endmodule

bind button_hold_click_drive_selector_unit bhcds_checker u_bhcds_checker (.*);

`default_nettype wire
